[rtl/core/rwct_pkg.sv]
// Shared types and constants of the random-walk cover-time engine.
package rwct_pkg;

    localparam int DEF_MAX_NODES    = 2048;
    localparam int DEF_STEP_BITS    = 40;
    localparam int WORD_W           = 32;
    localparam int KIND_W           = 3;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 12;
    localparam int NODE_COUNT_MIN   = 4;
    localparam int NODE_COUNT_RESET = 100;
    localparam int EPOCH_W          = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRAPH_KIND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(1);

    // Epoch zero marks an entry that no walk has touched since the last sweep.
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLIQUE   = 3'd0,
        KIND_PATH_END = 3'd1,
        KIND_PATH_MID = 3'd2,
        KIND_TREE     = 3'd3,
        KIND_LOLLIPOP = 3'd4
    } graph_kind_t;

    typedef struct packed {
        logic rd_en;
        logic mark_en;
        logic restart;
    } vmap_ctrl_t;

    typedef struct packed {
        logic load;
        logic restart;
    } nbr_ctrl_t;

endpackage

[rtl/core/rwct_vmap.sv]
// Visited map: epoch-tagged memory with a clearing sweep on epoch wrap.
module rwct_vmap #(
    parameter int  MAX_NODES = rwct_pkg::DEF_MAX_NODES,
    localparam int NODE_W    = $clog2(MAX_NODES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rwct_pkg::vmap_ctrl_t ctrl,
    input  logic [NODE_W-1:0]   rd_addr,
    input  logic [NODE_W-1:0]   mark_addr,
    output logic                visited,
    output logic                epoch_last,
    output logic                clearing
);

    localparam logic [NODE_W-1:0] LAST_ADDR = NODE_W'(MAX_NODES - 1);

    logic [rwct_pkg::EPOCH_W-1:0] mem [MAX_NODES];
    logic [rwct_pkg::EPOCH_W-1:0] rd_data_reg;
    logic [rwct_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic                         clear_active_reg, clear_active_next;
    logic [NODE_W-1:0]            clear_addr_reg, clear_addr_next;
    logic                         wr_en;
    logic [NODE_W-1:0]            wr_addr;
    logic [rwct_pkg::EPOCH_W-1:0] wr_data;

    assign epoch_last = (epoch_reg == rwct_pkg::EPOCH_LAST);
    assign clearing   = clear_active_reg;
    assign visited    = (rd_data_reg == epoch_reg);

    always_comb begin
        epoch_next        = epoch_reg;
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg) begin
            clear_addr_next = clear_addr_reg + NODE_W'(1);
            if (clear_addr_reg == LAST_ADDR) begin
                clear_active_next = 1'b0;
            end
        end
        if (ctrl.restart) begin
            if (epoch_last) begin
                epoch_next        = rwct_pkg::EPOCH_FIRST;
                clear_active_next = 1'b1;
                clear_addr_next   = '0;
            end else begin
                epoch_next = epoch_reg + rwct_pkg::EPOCH_W'(1);
            end
        end
    end

    // The sweep owns the write port; a mark is only written while it is idle.
    always_comb begin
        wr_en   = clear_active_reg || ctrl.mark_en;
        wr_addr = clear_active_reg ? clear_addr_reg : mark_addr;
        wr_data = clear_active_reg ? rwct_pkg::EPOCH_NONE : epoch_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg        <= rwct_pkg::EPOCH_FIRST;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end else begin
            epoch_reg        <= epoch_next;
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/rwct_nbr.sv]
// Neighbour selection: degree, scaled random index and topology lookup.
module rwct_nbr #(
    parameter int  MAX_NODES = rwct_pkg::DEF_MAX_NODES,
    localparam int NODE_W    = $clog2(MAX_NODES),
    localparam int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  logic                        aclk,
    input  rwct_pkg::nbr_ctrl_t         ctrl,
    input  logic [rwct_pkg::WORD_W-1:0] word,
    input  logic [NODE_W-1:0]           cur_node,
    input  logic [NODE_W-1:0]           start_node,
    input  rwct_pkg::graph_kind_t       kind,
    input  logic [CNT_W-1:0]            node_n,
    input  logic [CNT_W-1:0]            clique_c,
    output logic [NODE_W-1:0]           next_node
);

    localparam int IW = NODE_W + 2;
    localparam int PW = rwct_pkg::WORD_W + CNT_W;

    logic [rwct_pkg::WORD_W-1:0] word_reg;
    logic [CNT_W-1:0]            deg_reg;
    logic [NODE_W-1:0]           deg_node;
    logic [CNT_W-1:0]            deg_sel;
    logic [PW-1:0]               product;
    logic [NODE_W-1:0]           pick;
    logic [IW-1:0]               cand;

    function automatic logic [CNT_W-1:0] degree_of(rwct_pkg::graph_kind_t k,
                                                   logic [IW-1:0] n,
                                                   logic [IW-1:0] c,
                                                   logic [IW-1:0] i);
        logic [IW-1:0] d;
        logic [IW-1:0] left;
        left = (i << 1) + IW'(1);
        case (k)
            rwct_pkg::KIND_PATH_END, rwct_pkg::KIND_PATH_MID: begin
                d = (i == '0 || i == n - IW'(1)) ? IW'(1) : IW'(2);
            end
            rwct_pkg::KIND_TREE: begin
                if (i == '0) begin
                    d = IW'(2);
                end else begin
                    d = IW'(1) + IW'(left < n) + IW'(left + IW'(1) < n);
                end
            end
            rwct_pkg::KIND_LOLLIPOP: begin
                if (i < c) begin
                    d = c - IW'(1) + IW'(i == c - IW'(1));
                end else begin
                    d = (i == n - IW'(1)) ? IW'(1) : IW'(2);
                end
            end
            default: begin
                d = n - IW'(1);
            end
        endcase
        return d[CNT_W-1:0];
    endfunction

    function automatic logic [IW-1:0] neighbour_of(rwct_pkg::graph_kind_t k,
                                                   logic [IW-1:0] n,
                                                   logic [IW-1:0] c,
                                                   logic [IW-1:0] i,
                                                   logic [IW-1:0] j);
        logic [IW-1:0] r;
        logic [IW-1:0] left;
        logic [IW-1:0] skip;
        left = (i << 1) + IW'(1);
        skip = (j < i) ? j : j + IW'(1);
        case (k)
            rwct_pkg::KIND_PATH_END, rwct_pkg::KIND_PATH_MID: begin
                if (i == '0)               r = IW'(1);
                else if (i == n - IW'(1))  r = n - IW'(2);
                else                       r = (j == '0) ? i - IW'(1) : i + IW'(1);
            end
            rwct_pkg::KIND_TREE: begin
                if (i == '0)                     r = (j == '0) ? IW'(1) : IW'(2);
                else if (j == '0)                r = (i - IW'(1)) >> 1;
                else if (j == IW'(1) && left < n) r = left;
                else                             r = left + IW'(1);
            end
            rwct_pkg::KIND_LOLLIPOP: begin
                if (i < c)                 r = (j >= c - IW'(1)) ? c : skip;
                else if (i == n - IW'(1))  r = n - IW'(2);
                else                       r = (j == '0) ? i - IW'(1) : i + IW'(1);
            end
            default: begin
                r = skip;
            end
        endcase
        return r;
    endfunction

    // When the walk restarts at the same edge, the new item leaves the start node.
    assign deg_node = ctrl.restart ? start_node : cur_node;
    assign deg_sel  = degree_of(kind, IW'(node_n), IW'(clique_c), IW'(deg_node));

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            word_reg <= word;
            deg_reg  <= deg_sel;
        end
    end

    assign product = PW'(word_reg) * PW'(deg_reg);
    assign pick    = product[rwct_pkg::WORD_W +: NODE_W];
    assign cand    = neighbour_of(kind, IW'(node_n), IW'(clique_c), IW'(cur_node), IW'(pick));

    assign next_node = (cand >= IW'(node_n)) ? '0 : cand[NODE_W-1:0];

endmodule

[rtl/core/random_walk_cover_time_core.sv]
// Top level of the random-walk cover-time engine: control, counters and result register.
//
// Channel  | Ports                                         | Role
// ---------+-----------------------------------------------+-----------------------------
// input    | s_valid s_ready s_random_word                 | one random word per step
// result   | m_valid m_ready m_position m_step_count       | one result per step
//          | m_first_visit m_cover_done                    |
// config   | cfg_valid cfg_ready cfg_index cfg_wdata       | register writes, always ready
//
// A step passes a lookup stage, then a map-read stage; the next word is taken only once the
// previous step has left the lookup stage. The degree of the current node is registered with
// the word at the input transfer; the 32-bit scaling multiply and the neighbour lookup then
// settle the new current node in the lookup stage; the visited-map read resolves after it.
// After reset, and again after every 255th walk, a sweep clears the whole visited map,
// during which no input transfer is taken.
// A result waiting on m_ready holds in the output register while one further step
// advances as far as the map read and waits there.
module random_walk_cover_time_core #(
    parameter int  MAX_NODES = rwct_pkg::DEF_MAX_NODES,
    parameter int  STEP_BITS = rwct_pkg::DEF_STEP_BITS,
    localparam int NODE_W    = $clog2(MAX_NODES),
    localparam int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rwct_pkg::WORD_W-1:0]     s_random_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [NODE_W-1:0]               m_position,
    output logic [STEP_BITS-1:0]            m_step_count,
    output logic                            m_first_visit,
    output logic                            m_cover_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwct_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Reset node count after clamping to the supported range, and its clique size.
    localparam int N_RESET = (rwct_pkg::NODE_COUNT_RESET > MAX_NODES) ?
                             MAX_NODES : rwct_pkg::NODE_COUNT_RESET;
    localparam int C_RESET = 2 * N_RESET / 3;
    localparam int XW      = CNT_W + 1;
    localparam logic [XW-1:0] RECIP3 = XW'((64'd1 << XW) / 64'd3);
    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

    // Configuration, held in its effective form.
    rwct_pkg::graph_kind_t kind_reg, kind_new;
    logic [CNT_W-1:0]      n_reg, n_new;
    logic [CNT_W-1:0]      c_reg, c_new;
    logic [NODE_W-1:0]     start_reg, start_new;

    // Walk state and pipeline control.
    logic [NODE_W-1:0]     cur_node_reg, cur_node_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [STEP_BITS-1:0]  steps_reg, steps_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s2_valid_reg, s2_valid_next;
    logic [NODE_W-1:0]     s2_node_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]     pos_reg;
    logic [STEP_BITS-1:0]  step_out_reg;
    logic                  first_reg;
    logic                  done_reg;

    logic                  accept, cfg_write, out_free, s2_fire, restart_step;
    logic                  visited_hit, epoch_last, clearing, first_now, done_now;
    logic [CNT_W-1:0]      total_inc;
    logic [STEP_BITS-1:0]  steps_inc;
    logic [NODE_W-1:0]     next_node;
    logic [XW-1:0]         twice_n, quot0, rem0;
    logic [2*XW-1:0]       recip_prod;

    rwct_pkg::vmap_ctrl_t  vmap_ctrl;
    rwct_pkg::nbr_ctrl_t   nbr_ctrl;

    // A write to a listed register restarts the walk; other indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid &&
                       (cfg_index == rwct_pkg::REG_GRAPH_KIND ||
                        cfg_index == rwct_pkg::REG_NODE_COUNT);

    always_comb begin
        kind_new = kind_reg;
        n_new    = n_reg;
        if (cfg_index == rwct_pkg::REG_GRAPH_KIND) begin
            if (cfg_wdata[rwct_pkg::KIND_W-1:0] inside
                    {[rwct_pkg::KIND_CLIQUE:rwct_pkg::KIND_LOLLIPOP]}) begin
                kind_new = rwct_pkg::graph_kind_t'(cfg_wdata[rwct_pkg::KIND_W-1:0]);
            end else begin
                kind_new = rwct_pkg::KIND_CLIQUE;
            end
        end
        if (cfg_index == rwct_pkg::REG_NODE_COUNT) begin
            if (32'(cfg_wdata) < rwct_pkg::NODE_COUNT_MIN) begin
                n_new = CNT_W'(rwct_pkg::NODE_COUNT_MIN);
            end else if (32'(cfg_wdata) > MAX_NODES) begin
                n_new = CNT_W'(MAX_NODES);
            end else begin
                n_new = CNT_W'(cfg_wdata);
            end
        end
    end

    // Clique size 2n/3 by reciprocal multiplication; one correction step suffices.
    always_comb begin
        twice_n    = {n_new, 1'b0};
        recip_prod = (2*XW)'(twice_n) * (2*XW)'(RECIP3);
        quot0      = recip_prod[XW +: XW];
        rem0       = twice_n - (quot0 + (quot0 << 1));
        c_new      = (rem0 >= XW'(3)) ? CNT_W'(quot0 + XW'(1)) : CNT_W'(quot0);
        start_new  = (kind_new == rwct_pkg::KIND_PATH_MID) ? NODE_W'(n_new >> 1) : '0;
    end

    // Result of the step in the map-read stage.
    assign first_now    = !(visited_hit || s2_node_reg == start_reg);
    assign total_inc    = total_reg + CNT_W'(first_now);
    assign done_now     = (total_inc >= n_reg);
    assign steps_inc    = (steps_reg == STEP_MAX) ? steps_reg : steps_reg + STEP_BITS'(1);
    assign out_free     = !m_valid_reg || m_ready;
    assign s2_fire      = s2_valid_reg && out_free;
    assign restart_step = s2_fire && done_now;

    // The next step may only start once the previous one has settled the current node.
    // A restart that wraps the epoch starts the sweep, so that edge takes no transfer.
    assign s_ready = !clearing && !s1_valid_reg && (!s2_valid_reg || s2_fire) &&
                     !(restart_step && epoch_last);
    assign accept  = s_valid && s_ready;

    assign nbr_ctrl.load    = accept;
    assign nbr_ctrl.restart = restart_step;

    assign vmap_ctrl.rd_en   = s1_valid_reg;
    assign vmap_ctrl.mark_en = s2_fire && first_now;
    assign vmap_ctrl.restart = restart_step || cfg_write;

    rwct_nbr #(
        .MAX_NODES (MAX_NODES)
    ) u_nbr (
        .aclk       (aclk),
        .ctrl       (nbr_ctrl),
        .word       (s_random_word),
        .cur_node   (cur_node_reg),
        .start_node (start_reg),
        .kind       (kind_reg),
        .node_n     (n_reg),
        .clique_c   (c_reg),
        .next_node  (next_node)
    );

    rwct_vmap #(
        .MAX_NODES (MAX_NODES)
    ) u_vmap (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (vmap_ctrl),
        .rd_addr    (next_node),
        .mark_addr  (s2_node_reg),
        .visited    (visited_hit),
        .epoch_last (epoch_last),
        .clearing   (clearing)
    );

    // The first stage always moves on in the following cycle, since it only fills when
    // the map-read stage is empty or emptying.
    always_comb begin
        s1_valid_next = accept;
        s2_valid_next = s1_valid_reg ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_reg);
        m_valid_next  = s2_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        cur_node_next = s1_valid_reg ? next_node : cur_node_reg;
        total_next    = total_reg;
        steps_next    = steps_reg;
        if (cfg_write) begin
            cur_node_next = start_new;
            total_next    = CNT_W'(1);
            steps_next    = '0;
        end else if (restart_step) begin
            cur_node_next = start_reg;
            total_next    = CNT_W'(1);
            steps_next    = '0;
        end else if (s2_fire) begin
            total_next = total_inc;
            steps_next = steps_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= rwct_pkg::KIND_CLIQUE;
            n_reg        <= CNT_W'(N_RESET);
            c_reg        <= CNT_W'(C_RESET);
            start_reg    <= '0;
            cur_node_reg <= '0;
            total_reg    <= CNT_W'(1);
            steps_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_write) begin
                kind_reg  <= kind_new;
                n_reg     <= n_new;
                c_reg     <= c_new;
                start_reg <= start_new;
            end
            cur_node_reg <= cur_node_next;
            total_reg    <= total_next;
            steps_reg    <= steps_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_node_reg <= next_node;
        end
        if (s2_fire) begin
            pos_reg      <= s2_node_reg;
            step_out_reg <= steps_inc;
            first_reg    <= first_now;
            done_reg     <= done_now;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_position    = pos_reg;
    assign m_step_count  = step_out_reg;
    assign m_first_visit = first_reg;
    assign m_cover_done  = done_reg;

`ifndef SYNTHESIS
    // Only one step is ever in flight between the two stages.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_valid_reg && s2_valid_reg))
        else $error("both pipeline stages occupied");

    a_s1_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |=> s2_valid_reg)
        else $error("first stage did not advance to the map read");

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != '0 && total_reg < n_reg)
        else $error("visited total outside one to n-1");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart_step |=> total_reg == CNT_W'(1) && steps_reg == '0 &&
                         cur_node_reg == start_reg)
        else $error("walk not restarted after cover");

    a_position_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> CNT_W'(pos_reg) < n_reg)
        else $error("reported position beyond node count");
`endif

endmodule

[tb/rwct_checker.sv]
// Checker that predicts every step of the random walk and compares each result transfer.
module rwct_checker
    import rwct_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int STEP_BITS = DEF_STEP_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic [WORD_W-1:0]                      s_random_word,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [$clog2(MAX_NODES)-1:0]           m_position,
    input  logic [STEP_BITS-1:0]                   m_step_count,
    input  logic                                   m_first_visit,
    input  logic                                   m_cover_done,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_wdata,
    output int                                     mismatch_count,
    output int                                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_W = $clog2(MAX_NODES);

    typedef struct packed {
        logic [NODE_W-1:0]    position;
        logic [STEP_BITS-1:0] step_count;
        logic                 first_visit;
        logic                 cover_done;
    } walk_step_t;

    logic [KIND_W-1:0]     kind_reg;
    logic [CFG_DATA_W-1:0] count_reg;
    int unsigned           here_node;
    bit                    seen_map [MAX_NODES];
    int unsigned           seen_total;
    logic [STEP_BITS-1:0]  step_total;
    walk_step_t            expected_steps [$];

    function automatic int unsigned nodes_in_use();
        int unsigned n;
        n = count_reg;
        if (n < NODE_COUNT_MIN) n = NODE_COUNT_MIN;
        if (n > MAX_NODES) n = MAX_NODES;
        return n;
    endfunction

    // Kinds beyond the lollipop fall back to the clique.
    function automatic graph_kind_t kind_in_use();
        if (kind_reg > KIND_LOLLIPOP) return KIND_CLIQUE;
        return graph_kind_t'(kind_reg);
    endfunction

    function automatic void restart_walk();
        int unsigned n;
        n = nodes_in_use();
        foreach (seen_map[j]) seen_map[j] = 1'b0;
        here_node = (kind_in_use() == KIND_PATH_MID) ? n / 2 : 0;
        seen_map[here_node] = 1'b1;
        seen_total = 1;
        step_total = '0;
    endfunction

    function automatic int unsigned degree_of(graph_kind_t kind, int unsigned n,
                                              int unsigned i);
        int unsigned c;
        c = 2 * n / 3;
        case (kind)
            KIND_PATH_END, KIND_PATH_MID: return (i == 0 || i == n - 1) ? 1 : 2;
            KIND_TREE: begin
                if (i == 0) return 2;
                return 1 + ((2 * i + 1 < n) ? 1 : 0) + ((2 * i + 2 < n) ? 1 : 0);
            end
            KIND_LOLLIPOP: begin
                if (i < c) return (c - 1) + ((i == c - 1) ? 1 : 0);
                if (i == n - 1) return 1;
                return 2;
            end
            default: return n - 1;
        endcase
    endfunction

    function automatic int unsigned neighbour_of(graph_kind_t kind, int unsigned n,
                                                 int unsigned i, int unsigned k);
        int unsigned c;
        c = 2 * n / 3;
        case (kind)
            KIND_PATH_END, KIND_PATH_MID: begin
                if (i == 0) return 1;
                if (i == n - 1) return n - 2;
                return (k == 0) ? i - 1 : i + 1;
            end
            KIND_TREE: begin
                if (i == 0) return (k == 0) ? 1 : 2;
                if (k == 0) return (i - 1) / 2;
                if (k == 1 && 2 * i + 1 < n) return 2 * i + 1;
                return 2 * i + 2;
            end
            KIND_LOLLIPOP: begin
                if (i < c) begin
                    // The last clique node carries the path head as its final neighbour.
                    if (k >= c - 1) return c;
                    return (k < i) ? k : k + 1;
                end
                if (i == n - 1) return n - 2;
                return (k == 0) ? i - 1 : i + 1;
            end
            default: return (k < i) ? k : k + 1;
        endcase
    endfunction

    function automatic walk_step_t take_step(logic [WORD_W-1:0] word);
        walk_step_t  r;
        int unsigned n;
        int unsigned deg;
        int unsigned pick;
        int unsigned src;
        int unsigned dst;
        graph_kind_t kind;
        logic [63:0] scaled;
        n = nodes_in_use();
        kind = kind_in_use();
        src = (here_node < n) ? here_node : 0;
        deg = degree_of(kind, n, src);
        scaled = 64'(word) * 64'(deg);
        pick = scaled[63:32];
        dst = neighbour_of(kind, n, src, pick);
        if (dst >= n) dst = 0;
        here_node = dst;
        r.first_visit = 1'b0;
        if (!seen_map[dst]) begin
            seen_map[dst] = 1'b1;
            seen_total++;
            r.first_visit = 1'b1;
        end
        if (step_total != '1) step_total++;
        r.position = NODE_W'(dst);
        r.step_count = step_total;
        r.cover_done = (seen_total >= n);
        if (r.cover_done) restart_walk();
        return r;
    endfunction

    always @(posedge aclk) begin
        walk_step_t want;
        if (!aresetn) begin
            kind_reg = KIND_CLIQUE;
            count_reg = CFG_DATA_W'(NODE_COUNT_RESET);
            restart_walk();
            expected_steps.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_steps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with none expected: position %0d steps %0d",
                                 $time, m_position, m_step_count);
                end else begin
                    want = expected_steps.pop_front();
                    if (m_position !== want.position || m_step_count !== want.step_count ||
                        m_first_visit !== want.first_visit ||
                        m_cover_done !== want.cover_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: step mismatch: expected pos %0d steps %0d first %0b ",
                                      "cover %0b, got pos %0d steps %0d first %0b cover %0b"},
                                     $time, want.position, want.step_count, want.first_visit,
                                     want.cover_done, m_position, m_step_count, m_first_visit,
                                     m_cover_done);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GRAPH_KIND: begin
                        kind_reg = cfg_wdata[KIND_W-1:0];
                        restart_walk();
                    end
                    REG_NODE_COUNT: begin
                        count_reg = cfg_wdata;
                        restart_walk();
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_steps.insert(expected_steps.size(), take_step(s_random_word));
        end
        outstanding = expected_steps.size();
    end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, stimulus and verdict for the random-walk cover-time core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rwct_pkg::*;

    localparam int MAX_NODES     = DEF_MAX_NODES;
    localparam int STEP_BITS     = DEF_STEP_BITS;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int CALM_ITEMS    = 200;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Kind codes that the block has no graph for; both must act as the clique.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_W'(5);
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;
    // A register index well past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_random_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [NODE_W-1:0]     m_position;
    logic [STEP_BITS-1:0]  m_step_count;
    logic                  m_first_visit;
    logic                  m_cover_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int hold_requests = 0;
    bit calm = 1'b0;
    bit gappy = 1'b1;

    random_walk_cover_time_core #(
        .MAX_NODES(MAX_NODES),
        .STEP_BITS(STEP_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_random_word(s_random_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_position(m_position),
        .m_step_count(m_step_count),
        .m_first_visit(m_first_visit),
        .m_cover_done(m_cover_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    rwct_checker #(
        .MAX_NODES(MAX_NODES),
        .STEP_BITS(STEP_BITS)
    ) step_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_random_word(s_random_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_position(m_position),
        .m_step_count(m_step_count),
        .m_first_visit(m_first_visit),
        .m_cover_done(m_cover_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count),
        .outstanding(outstanding)
    );

    // A 20 ns clock. Stimulus moves on the falling edge and everything is sampled on the
    // rising edge, so nothing hangs on the order of events within a time step.
    initial aclk = 1'b0;
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Watchdog. The limit sits several times above the slowest correct run, which
    // includes the clearing sweeps of the visited map after reset and every 255th walk.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("random_walk_cover_time_core test failed");
            $finish;
        end
    end

    // Stops offering input and waits until every predicted step has come back out.
    task automatic wait_drained();
        s_valid = 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Register writes happen only with the block idle, so the walk state that the
    // checker restarts matches the state inside the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_index = idx;
        cfg_wdata = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Offers one random word. Valid stays high across back-to-back items, and a gap is
    // put in front of some items while noise sits on the bus.
    task automatic send_word(input logic [WORD_W-1:0] w);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            s_random_word = $urandom;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_random_word = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Receiver. It stalls in short random bursts, and once in a while holds off for a
    // long stretch on request, so that the block fills up and pushes back on its input.
    // In the calm tail of the run it accepts every result at once.
    initial begin
        int holds_served;
        holds_served = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    initial begin
        int unsigned           sent;
        int unsigned           phase_no;
        int unsigned           phase_items;
        int unsigned           live_count;
        int unsigned           r;
        logic [CFG_DATA_W-1:0] kind_word;
        logic [CFG_DATA_W-1:0] count_word;
        logic [WORD_W-1:0]     word;

        s_valid = 1'b0;
        s_random_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. The reset setting is a clique of 100 nodes; the two extreme
        // words pick the first and the last neighbour, and the middle word lands midway.
        send_word('0);
        send_word('1);
        send_word(32'h8000_0000);

        // A write past the register list must leave the walk where it is.
        write_reg(REG_SPARE, '1);
        send_word(32'h0000_0001);

        // Unknown kind acts as the clique, and a node count of three is raised to four.
        // The first three words visit nodes 1, 2 and 3 in turn, so the third step reports
        // cover and the walk starts again from node 0.
        write_reg(REG_GRAPH_KIND, {{(CFG_DATA_W - KIND_W){1'b1}}, KIND_SPARE_HI});
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(3));
        send_word('0);
        send_word(32'h8000_0000);
        send_word('1);
        send_word('0);

        // Path from an end with four nodes: walking straight out covers it.
        write_reg(REG_GRAPH_KIND, CFG_DATA_W'(KIND_PATH_END));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(NODE_COUNT_MIN));
        send_word('1);
        send_word('1);
        send_word('1);
        send_word('0);

        // Path from the middle, with a node count above the limit that is cut back.
        write_reg(REG_GRAPH_KIND, CFG_DATA_W'(KIND_PATH_MID));
        write_reg(REG_NODE_COUNT, '1);
        send_word('1);
        send_word('0);

        // Binary tree at the largest size.
        write_reg(REG_GRAPH_KIND, CFG_DATA_W'(KIND_TREE));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(MAX_NODES));
        send_word('0);
        send_word('1);
        send_word('1);

        // Lollipop of six nodes: the walk crosses from the clique onto the path.
        write_reg(REG_GRAPH_KIND, CFG_DATA_W'(KIND_LOLLIPOP));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(6));
        repeat (4) send_word('1);

        // The other unknown kind, one node past the limit, then a node count of zero.
        write_reg(REG_GRAPH_KIND, CFG_DATA_W'(KIND_SPARE_LO));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(MAX_NODES + 1));
        send_word('0);
        write_reg(REG_NODE_COUNT, '0);
        write_reg(REG_GRAPH_KIND, CFG_DATA_W'(KIND_CLIQUE));
        send_word('1);
        send_word('0);

        // Random part. Each phase picks a graph and a size, mostly small so that walks
        // reach cover often, with the odd extreme or large size among them.
        live_count = 0;
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_no++;
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_NODE_COUNT + 1, 2**CFG_IDX_W - 1)),
                          CFG_DATA_W'($urandom));

            r = $urandom_range(0, 11);
            kind_word = CFG_DATA_W'($urandom);
            kind_word[KIND_W-1:0] = (r < 10) ? KIND_W'(r % 5)
                                             : KIND_W'($urandom_range(KIND_SPARE_LO,
                                                                      KIND_SPARE_HI));
            case ($urandom_range(0, 19))
                0:       count_word = CFG_DATA_W'($urandom_range(0, NODE_COUNT_MIN - 1));
                1:       count_word = CFG_DATA_W'($urandom_range(MAX_NODES,
                                                                 2**CFG_DATA_W - 1));
                2:       count_word = CFG_DATA_W'($urandom_range(25, 200));
                default: count_word = CFG_DATA_W'($urandom_range(NODE_COUNT_MIN, 16));
            endcase

            // Sometimes only one of the two registers changes.
            r = $urandom_range(0, 3);
            if (r != 1) write_reg(REG_GRAPH_KIND, kind_word);
            if (r != 0 || phase_no == 1) begin
                write_reg(REG_NODE_COUNT, count_word);
                live_count = count_word;
            end

            phase_items = (live_count > 200) ? 40 : $urandom_range(40, 120);
            gappy = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < phase_items; i++) begin
                // In the second phase the receiver holds off for a long stretch while
                // words keep coming; in the fourth the sender waits for the block to empty.
                if (phase_no == 2 && i == phase_items / 2) hold_requests++;
                if (phase_no == 4 && i == phase_items / 2) wait_drained();
                if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
                case ($urandom_range(0, 15))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                send_word(word);
                sent++;
            end
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("random_walk_cover_time_core test passed");
        else
            $display("random_walk_cover_time_core test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rwct_pkg.sv
rtl/core/rwct_vmap.sv
rtl/core/rwct_nbr.sv
rtl/core/random_walk_cover_time_core.sv
tb/rwct_checker.sv
tb/testbench.sv
